>>> rtl/mbrm_pkg.sv
// Shared types, codes and the CRC-16 byte update for the Modbus RTU
// single-register master. No dependencies.
package mbrm_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RX    = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BUSY    = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic CFG_SLAVE_ADDR = 1'b0;
    localparam logic CFG_TIMEOUT    = 1'b1;

    localparam logic [7:0]  FUNC_READ  = 8'h03;
    localparam logic [7:0]  FUNC_WRITE = 8'h06;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] CRC_PRESET = 16'hFFFF;

    localparam logic [7:0]  SLAVE_ADDR_RESET = 8'd1;
    localparam logic [15:0] TIMEOUT_RESET    = 16'd200;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] reg_address;
        logic [15:0] write_value;
        logic [7:0]  rx_byte;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic [1:0]  status;
        logic [15:0] read_value;
        logic        last;
    } t_out;

    typedef logic [7:0][7:0] t_frame;

    // load command from the controller to the transmit sequencer
    typedef struct packed {
        logic            valid;
        logic            is_frame;
        logic [5:0][7:0] head;    // frame bytes 0..5, CRC is added on the way out
        logic [1:0]      status;
        logic [15:0]     value;
    } t_cmd;

    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/modbus_rtu_single_register_master.sv
// Modbus RTU single-register master, top level. Instantiates mbrm_ctrl and
// mbrm_tx; uses mbrm_pkg.
//
// A read or write request produces eight transmit-byte results, one per
// cycle while i_out_stall is low: the frame leaves one result register a
// byte per transfer, its CRC-16 built byte by byte as it goes. Received
// bytes, ticks and busy rejects pass through the input register and yield
// at most one status result. An item waits in the input register while the
// result register still sends the previous item's results; it moves on in
// the cycle the last one transfers. Configuration (index 0 slave address,
// index 1 timeout ticks) is written via i_cfg_we/i_cfg_index/i_cfg_data by
// the user only while no transaction is in flight, unchecked by the block.
module modbus_rtu_single_register_master import mbrm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out
);

    logic   tx_free;
    t_frame sent_frame;
    t_cmd   cmd;

    mbrm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in         (i_in),
        .i_tx_free    (tx_free),
        .i_sent_frame (sent_frame),
        .o_cmd        (cmd)
    );

    mbrm_tx u_tx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_free       (tx_free),
        .o_sent_frame (sent_frame),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out        (o_out)
    );

endmodule

>>> rtl/mbrm_ctrl.sv
// Input register, configuration registers and transaction state.
// Decides the results of each item and hands them to mbrm_tx. Uses mbrm_pkg.
module mbrm_ctrl import mbrm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    input  logic        i_tx_free,
    input  t_frame      i_sent_frame,
    output t_cmd        o_cmd
);

    logic        r_in_valid;
    t_in         r_in;
    logic [7:0]  r_slave_addr;
    logic [15:0] r_timeout;
    logic        r_busy,     n_busy;
    logic        r_pend_wr,  n_pend_wr;
    t_frame      r_reply,    n_reply;
    logic [3:0]  r_cnt,      n_cnt;
    logic [15:0] r_elapsed,  n_elapsed;
    logic [15:0] r_rcrc,     n_rcrc;

    logic        advance;
    logic [3:0]  cnt_w;
    logic [7:0]  want_func;
    t_cmd        cmd;

    assign advance    = r_in_valid && i_tx_free;
    assign o_in_stall = r_in_valid && !advance;
    assign o_cmd      = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= SLAVE_ADDR_RESET;
            r_timeout    <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SLAVE_ADDR: r_slave_addr <= i_cfg_data[7:0];
                CFG_TIMEOUT:    r_timeout    <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb begin
        n_busy    = r_busy;
        n_pend_wr = r_pend_wr;
        n_reply   = r_reply;
        n_cnt     = r_cnt;
        n_elapsed = r_elapsed;
        n_rcrc    = r_rcrc;
        cnt_w     = (r_cnt > 4'd7) ? 4'd0 : r_cnt;
        want_func = r_pend_wr ? FUNC_WRITE : FUNC_READ;
        cmd       = '0;

        if (advance) begin
            unique case (r_in.opcode)
                OP_READ, OP_WRITE: begin
                    cmd.valid = 1'b1;
                    if (r_busy) begin
                        cmd.status = ST_BUSY;
                    end else begin
                        n_pend_wr    = (r_in.opcode == OP_WRITE);
                        n_busy       = 1'b1;
                        n_cnt        = 4'd0;
                        n_elapsed    = 16'd0;
                        n_rcrc       = CRC_PRESET;
                        cmd.is_frame = 1'b1;
                        cmd.head[0]  = r_slave_addr;
                        cmd.head[1]  = n_pend_wr ? FUNC_WRITE : FUNC_READ;
                        cmd.head[2]  = r_in.reg_address[15:8];
                        cmd.head[3]  = r_in.reg_address[7:0];
                        cmd.head[4]  = n_pend_wr ? r_in.write_value[15:8] : 8'h00;
                        cmd.head[5]  = n_pend_wr ? r_in.write_value[7:0]  : 8'h01;
                    end
                end
                OP_RX: begin
                    if (r_busy) begin
                        n_reply[cnt_w[2:0]] = r_in.rx_byte;
                        if (cnt_w < 4'd5) begin
                            n_rcrc = crc_add(r_rcrc, r_in.rx_byte);
                        end
                        n_cnt = cnt_w + 4'd1;
                        if (n_cnt == 4'd5) begin
                            if (n_reply[1] != want_func) begin
                                cmd.valid  = 1'b1;
                                cmd.status = ST_ERROR;
                            end
                        end else if (!r_pend_wr && n_cnt == 4'd7) begin
                            cmd.valid = 1'b1;
                            if ({n_reply[6], n_reply[5]} != n_rcrc) begin
                                cmd.status = ST_ERROR;
                            end else begin
                                cmd.status = ST_OK;
                                cmd.value  = {n_reply[3], n_reply[4]};
                            end
                        end else if (r_pend_wr && n_cnt == 4'd8) begin
                            cmd.valid  = 1'b1;
                            cmd.status = (n_reply != i_sent_frame) ? ST_ERROR : ST_OK;
                        end
                    end
                end
                OP_TICK: begin
                    if (r_busy) begin
                        if (r_elapsed >= r_timeout) begin
                            cmd.valid  = 1'b1;
                            cmd.status = ST_TIMEOUT;
                        end else begin
                            n_elapsed = r_elapsed + 16'd1;
                        end
                    end
                end
                default: ;
            endcase
            // status reports other than a busy reject end the transaction
            if (cmd.valid && !cmd.is_frame && cmd.status != ST_BUSY) begin
                n_busy = 1'b0;
                n_cnt  = 4'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_pend_wr <= 1'b0;
            r_cnt     <= 4'd0;
            r_elapsed <= 16'd0;
            r_rcrc    <= CRC_PRESET;
        end else begin
            r_busy    <= n_busy;
            r_pend_wr <= n_pend_wr;
            r_cnt     <= n_cnt;
            r_elapsed <= n_elapsed;
            r_rcrc    <= n_rcrc;
        end
        r_reply <= n_reply;
    end

endmodule

>>> rtl/mbrm_tx.sv
// Result register and frame sequencer: streams the stored request frame one
// byte per transfer, appending the CRC, or presents one status report. Uses mbrm_pkg.
module mbrm_tx import mbrm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_cmd,
    output logic   o_free,
    output t_frame o_sent_frame,
    output logic   o_out_valid,
    input  logic   i_out_stall,
    output t_out   o_out
);

    t_frame      r_frame;
    logic [2:0]  r_idx;
    logic        r_stream;
    logic        r_stat_vld;
    logic [1:0]  r_status;
    logic [15:0] r_value;
    logic [15:0] r_crc;

    logic        xfer;
    logic [15:0] crc_next;

    assign o_out_valid  = r_stream || r_stat_vld;
    assign xfer         = o_out_valid && !i_out_stall;
    assign o_free       = !o_out_valid || (xfer && (r_stat_vld || r_idx == 3'd7));
    assign o_sent_frame = r_frame;
    assign crc_next     = crc_add(r_crc, r_frame[r_idx]);

    always_comb begin
        o_out = '0;
        if (r_stream) begin
            o_out.kind    = KIND_TX;
            o_out.tx_byte = r_frame[r_idx];
            o_out.last    = (r_idx == 3'd7);
        end else begin
            o_out.kind       = KIND_STATUS;
            o_out.status     = r_status;
            o_out.read_value = r_value;
            o_out.last       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream   <= 1'b0;
            r_stat_vld <= 1'b0;
            r_idx      <= 3'd0;
        end else begin
            if (i_cmd.valid) begin
                r_stream   <= i_cmd.is_frame;
                r_stat_vld <= !i_cmd.is_frame;
                r_idx      <= 3'd0;
            end else if (xfer) begin
                if (r_stream) begin
                    r_idx <= r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        r_stream <= 1'b0;
                    end
                end else begin
                    r_stat_vld <= 1'b0;
                end
            end
        end

        // CRC runs over bytes 0..5 as they go out; bytes 6 and 7 fill in behind
        if (xfer && r_stream && r_idx < 3'd6) begin
            r_crc <= crc_next;
            if (r_idx == 3'd5) begin
                r_frame[6] <= crc_next[7:0];
                r_frame[7] <= crc_next[15:8];
            end
        end
        if (i_cmd.valid) begin
            r_status <= i_cmd.status;
            r_value  <= i_cmd.value;
            if (i_cmd.is_frame) begin
                r_frame[5:0] <= i_cmd.head;
                r_crc        <= CRC_PRESET;
            end
        end
    end

endmodule

>>> sim/modbus_rtu_single_register_master_test.sv
// Testbench for modbus_rtu_single_register_master: predicts transmit bytes and
// transaction status per input transfer and checks every output transfer.
// Depends on rtl/mbrm_pkg.sv and the top-level RTL.
`timescale 1ns / 1ps

module modbus_rtu_single_register_master_test;
    import mbrm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [7:0] EXCEPTION_FLAG = 8'h80;
    localparam logic [7:0] READ_BYTE_COUNT = 8'h02;

    typedef enum int {
        REPLY_GOOD,
        REPLY_BIT_ERROR,
        REPLY_BAD_FUNC,
        REPLY_SHORT
    } reply_kind_e;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_SLAVE_ADDR;
    logic [15:0] i_cfg_data = 16'h0000;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out;

    modbus_rtu_single_register_master dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // master state as the testbench sees it
    logic [7:0]  slave_addr_reg = SLAVE_ADDR_RESET;
    logic [15:0] timeout_reg = TIMEOUT_RESET;
    logic        txn_busy = 1'b0;
    logic        txn_is_write = 1'b0;
    t_frame      sent_frame = '0;
    t_frame      reply_frame = '0;
    int          reply_len = 0;
    logic [15:0] tick_count = 16'h0000;
    logic [15:0] reply_crc = CRC_PRESET;

    t_out        awaited_results[$];
    int          mismatches = 0;
    int          items_done = 0;
    bit          steady_input = 1'b0;
    int unsigned cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // bit-serial form of the Modbus CRC-16
    function automatic logic [15:0] modbus_crc_byte(input logic [15:0] acc, input logic [7:0] data);
        logic [15:0] c;
        c = acc;
        for (int b = 0; b < 8; b++) begin
            if (c[0] ^ data[b])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic void await_result(input logic kind, input logic [7:0] tx,
                                         input logic [1:0] st, input logic [15:0] value,
                                         input logic last);
        t_out r;
        r.kind = kind;
        r.tx_byte = tx;
        r.status = st;
        r.read_value = value;
        r.last = last;
        awaited_results.push_back(r);
    endfunction

    function automatic void end_transaction(input logic [1:0] st, input logic [15:0] value);
        txn_busy = 1'b0;
        reply_len = 0;
        await_result(KIND_STATUS, 8'h00, st, value, 1'b1);
    endfunction

    function automatic void predict_master(input t_in it);
        logic [15:0] crc;
        logic [7:0]  want_func;
        case (it.opcode)
            OP_READ, OP_WRITE: begin
                if (txn_busy) begin
                    // rejected: stored frame and timer untouched
                    await_result(KIND_STATUS, 8'h00, ST_BUSY, 16'h0000, 1'b1);
                end else begin
                    txn_is_write = (it.opcode == OP_WRITE);
                    sent_frame[0] = slave_addr_reg;
                    sent_frame[1] = txn_is_write ? FUNC_WRITE : FUNC_READ;
                    sent_frame[2] = it.reg_address[15:8];
                    sent_frame[3] = it.reg_address[7:0];
                    sent_frame[4] = txn_is_write ? it.write_value[15:8] : 8'h00;
                    sent_frame[5] = txn_is_write ? it.write_value[7:0] : 8'h01;
                    crc = CRC_PRESET;
                    for (int i = 0; i < 6; i++)
                        crc = modbus_crc_byte(crc, sent_frame[i]);
                    sent_frame[6] = crc[7:0];
                    sent_frame[7] = crc[15:8];
                    txn_busy = 1'b1;
                    reply_len = 0;
                    tick_count = 16'h0000;
                    reply_crc = CRC_PRESET;
                    for (int i = 0; i < 8; i++)
                        await_result(KIND_TX, sent_frame[i], ST_OK, 16'h0000, i == 7);
                end
            end
            OP_RX: begin
                if (txn_busy) begin
                    if (reply_len > 7)
                        reply_len = 0;
                    reply_frame[reply_len] = it.rx_byte;
                    if (reply_len < 5)
                        reply_crc = modbus_crc_byte(reply_crc, it.rx_byte);
                    reply_len++;
                    want_func = txn_is_write ? FUNC_WRITE : FUNC_READ;
                    if (reply_len == 5) begin
                        if (reply_frame[1] != want_func)
                            end_transaction(ST_ERROR, 16'h0000);
                    end else if (!txn_is_write && reply_len == 7) begin
                        if ({reply_frame[6], reply_frame[5]} != reply_crc)
                            end_transaction(ST_ERROR, 16'h0000);
                        else
                            end_transaction(ST_OK, {reply_frame[3], reply_frame[4]});
                    end else if (txn_is_write && reply_len == 8) begin
                        if (reply_frame != sent_frame)
                            end_transaction(ST_ERROR, 16'h0000);
                        else
                            end_transaction(ST_OK, 16'h0000);
                    end
                end
            end
            default: begin
                if (txn_busy) begin
                    if (tick_count >= timeout_reg)
                        end_transaction(ST_TIMEOUT, 16'h0000);
                    else
                        tick_count = tick_count + 16'd1;
                end
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // valid is left high after a transfer; the next call lowers it only before a gap, release_input_and_drain always
    task automatic send_item(input t_in it);
        int gap;
        gap = steady_input ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        if (txn_busy || it.opcode == OP_READ || it.opcode == OP_WRITE)
            items_done++;
        predict_master(it);
    endtask

    task automatic send_op(input logic [1:0] op, input logic [15:0] reg_a,
                           input logic [15:0] value, input logic [7:0] rx);
        t_in it;
        it.opcode = op;
        it.reg_address = reg_a;
        it.write_value = value;
        it.rx_byte = rx;
        send_item(it);
    endtask

    task automatic send_tick();
        send_op(OP_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
    endtask

    task automatic send_request();
        send_op(($urandom_range(0, 1) != 0) ? OP_WRITE : OP_READ,
                16'($urandom), 16'($urandom), 8'($urandom));
    endtask

    task automatic send_bytes(input t_frame f, input int n, input int tick_pct);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < tick_pct)
                send_tick();
            if (!txn_busy)
                break;
            send_op(OP_RX, 16'($urandom), 16'($urandom), f[i]);
        end
    endtask

    function automatic t_frame build_read_reply(input logic [7:0] addr, input logic [7:0] count,
                                                input logic [15:0] value);
        t_frame f;
        logic [15:0] crc;
        f = '0;
        f[0] = addr;
        f[1] = FUNC_READ;
        f[2] = count;
        f[3] = value[15:8];
        f[4] = value[7:0];
        crc = CRC_PRESET;
        for (int i = 0; i < 5; i++)
            crc = modbus_crc_byte(crc, f[i]);
        f[5] = crc[7:0];
        f[6] = crc[15:8];
        return f;
    endfunction

    task automatic send_reply(input reply_kind_e how, input int tick_pct);
        t_frame f;
        int n;
        int pos;
        int pick;
        if (txn_is_write) begin
            f = sent_frame;
            n = 8;
        end else begin
            // address and byte count are not checked by the master
            f = build_read_reply(($urandom_range(0, 4) == 0) ? 8'($urandom) : sent_frame[0],
                                 ($urandom_range(0, 4) == 0) ? 8'($urandom) : READ_BYTE_COUNT,
                                 16'($urandom));
            n = 7;
        end
        case (how)
            REPLY_BIT_ERROR: begin
                pos = $urandom_range(0, n - 1);
                f[pos] = f[pos] ^ (8'h01 << $urandom_range(0, 7));
            end
            REPLY_BAD_FUNC: begin
                pick = $urandom_range(0, 2);
                if (pick == 0)
                    f[1] = f[1] | EXCEPTION_FLAG;
                else if (pick == 1)
                    f[1] = txn_is_write ? FUNC_READ : FUNC_WRITE;
                else
                    f[1] = 8'($urandom);
                n = 5;
            end
            REPLY_SHORT: n = $urandom_range(1, 4);
            default: ;
        endcase
        send_bytes(f, n, tick_pct);
    endtask

    // random bytes always end a transaction within eight transfers
    task automatic close_transaction();
        while (txn_busy)
            send_op(OP_RX, 16'($urandom), 16'($urandom), 8'($urandom));
    endtask

    task automatic release_input_and_drain();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic index, input logic [15:0] data);
        close_transaction();
        release_input_and_drain();
        i_cfg_index <= index;
        i_cfg_data <= data;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == CFG_SLAVE_ADDR)
            slave_addr_reg = data[7:0];
        else
            timeout_reg = data;
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_out));
            end else begin
                want = awaited_results.pop_front();
                if (o_out.kind !== want.kind)
                    report_mismatch($sformatf("kind %b, want %b", o_out.kind, want.kind));
                if (o_out.tx_byte !== want.tx_byte)
                    report_mismatch($sformatf("tx_byte %h, want %h",
                                              o_out.tx_byte, want.tx_byte));
                if (o_out.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_out.status, want.status));
                if (o_out.read_value !== want.read_value)
                    report_mismatch($sformatf("read_value %h, want %h",
                                              o_out.read_value, want.read_value));
                if (o_out.last !== want.last)
                    report_mismatch($sformatf("last %b, want %b", o_out.last, want.last));
            end
        end
    end

    // output back-pressure: mostly short stalls, now and then a long one or a quiet stretch
    initial begin
        int run_len;
        int stall_len;
        forever begin
            run_len = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 5);
            i_out_stall <= 1'b0;
            repeat (run_len) @(posedge i_clk);
            stall_len = pick_gap();
            if (stall_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
        end
    end

    // reset values of both registers; reply address and byte count ignored
    task automatic test_read_with_defaults();
        send_op(OP_READ, 16'h0000, 16'hFFFF, 8'hFF);
        send_bytes(build_read_reply(8'hF7, 8'hFF, 16'hFFFF), 7, 0);
    endtask

    // rejected requests must leave the stored frame alone; then a broken echo
    task automatic test_busy_and_echo();
        t_frame f;
        send_op(OP_WRITE, 16'hFFFF, 16'hFFFF, 8'h00);
        send_op(OP_READ, 16'h0000, 16'h0000, 8'h00);
        send_op(OP_WRITE, 16'h5A5A, 16'hA5A5, 8'h00);
        f = sent_frame;
        f[7] = f[7] ^ 8'h80;
        send_bytes(f, 8, 0);
    endtask

    task automatic test_idle_inputs();
        send_op(OP_RX, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_op(OP_TICK, 16'h0000, 16'h0000, 8'h00);
    endtask

    task automatic test_reply_errors();
        t_frame f;
        send_op(OP_READ, 16'h1234, 16'h0000, 8'h00);
        f = build_read_reply(sent_frame[0], READ_BYTE_COUNT, 16'hA5A5);
        f[6] = f[6] ^ 8'h01;
        send_bytes(f, 7, 0);
        // exception reply ends after the fifth transfer
        send_op(OP_WRITE, 16'h00FF, 16'hFF00, 8'h00);
        f = sent_frame;
        f[1] = FUNC_WRITE | EXCEPTION_FLAG;
        send_bytes(f, 5, 0);
    endtask

    task automatic test_timeout_limits();
        write_cfg(CFG_SLAVE_ADDR, 16'd0);
        write_cfg(CFG_TIMEOUT, 16'd0);
        send_op(OP_READ, 16'hFFFF, 16'h0000, 8'h00);
        send_tick();
        write_cfg(CFG_SLAVE_ADDR, 16'd247);
        write_cfg(CFG_TIMEOUT, 16'd1);
        send_op(OP_WRITE, 16'h0000, 16'h0000, 8'h00);
        send_tick();
        send_tick();
    endtask

    task automatic run_random_traffic(input int n);
        int stop_at;
        int r;
        stop_at = items_done + n;
        while (items_done < stop_at) begin
            steady_input = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 55) begin
                send_request();
                send_reply(($urandom_range(0, 9) < 7) ? REPLY_GOOD : REPLY_BIT_ERROR, 8);
            end else if (r < 65) begin
                send_request();
                send_reply(REPLY_BAD_FUNC, 8);
            end else if (r < 75) begin
                send_request();
                if (timeout_reg <= 16'd40) begin
                    while (txn_busy)
                        send_tick();
                end else begin
                    repeat (3) send_tick();
                    send_reply(REPLY_GOOD, 0);
                end
            end else if (r < 85) begin
                send_request();
                send_reply(REPLY_SHORT, 15);
            end else if (r < 92) begin
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 1) != 0)
                        send_tick();
                    else
                        send_op(OP_RX, 16'($urandom), 16'($urandom), 8'($urandom));
                end
            end else begin
                send_request();
                repeat ($urandom_range(1, 2)) send_request();
                send_reply(REPLY_GOOD, 8);
            end
            close_transaction();
        end
    endtask

    task automatic test_random_traffic();
        write_cfg(CFG_SLAVE_ADDR, 16'($urandom_range(0, 247)));
        write_cfg(CFG_TIMEOUT, 16'($urandom_range(2, 6)));
        run_random_traffic(100);
        write_cfg(CFG_SLAVE_ADDR, 16'd247);
        write_cfg(CFG_TIMEOUT, 16'd65535);
        run_random_traffic(100);
        write_cfg(CFG_SLAVE_ADDR, 16'd0);
        write_cfg(CFG_TIMEOUT, 16'd1);
        run_random_traffic(100);
        write_cfg(CFG_SLAVE_ADDR, 16'($urandom_range(0, 247)));
        write_cfg(CFG_TIMEOUT, 16'($urandom_range(7, 40)));
        run_random_traffic(90);
        write_cfg(CFG_SLAVE_ADDR, 16'(SLAVE_ADDR_RESET));
        write_cfg(CFG_TIMEOUT, TIMEOUT_RESET);
        run_random_traffic(60);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_read_with_defaults();
        test_busy_and_echo();
        test_idle_inputs();
        test_reply_errors();
        test_timeout_limits();
        test_random_traffic();

        release_input_and_drain();
        repeat (20) @(posedge i_clk);
        if (awaited_results.size() == 0 && mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/mbrm_pkg.sv
rtl/mbrm_ctrl.sv
rtl/mbrm_tx.sv
rtl/modbus_rtu_single_register_master.sv
sim/modbus_rtu_single_register_master_test.sv
